### rtl/bsf_pkg.sv
package bsf_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int MAX_WINDOW_DEF  = 64;
   localparam int WIN_RESET       = 5;

   // window length field as it sits in the register
   localparam int CFG_BITS = 7;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = CSR_ADDR_BITS - 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_IDX_WINDOW = '0;

   // engine to output stage: a word is ready for the output register
   typedef struct packed {
      logic valid;
      logic last;
   } emit_type;

endpackage

### rtl/bsf_if.sv
interface bsf_req_if #(
   parameter int SAMPLE_BITS = bsf_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface bsf_rsp_if #(
   parameter int SAMPLE_BITS = bsf_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] smoothed;
   logic                          last_output;

   modport source (output valid, output smoothed, output last_output, input ready);
   modport sink   (input valid, input smoothed, input last_output, output ready);
endinterface

### rtl/bsf_divider.sv
module bsf_divider #(
   parameter int SAMPLE_BITS = bsf_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_WINDOW  = bsf_pkg::MAX_WINDOW_DEF
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                start,
   input  logic signed [SAMPLE_BITS+$clog2(MAX_WINDOW)-1:0]    dividend,
   input  logic        [$clog2(MAX_WINDOW+1)-1:0]              divisor,
   output logic                                                busy,
   output logic signed [SAMPLE_BITS-1:0]                       quotient
);

   localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int WIN_BITS = $clog2(MAX_WINDOW + 1);
   localparam int CNT_BITS = $clog2(SAMPLE_BITS + 1);

   logic                   busy_ff, busy_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [WIN_BITS-1:0]    rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] shreg_ff, shreg_in;
   logic                   neg_ff, neg_in;

   logic [SUM_BITS-1:0]    magnitude;
   logic [WIN_BITS:0]      trial;
   logic                   qbit;

   always_comb begin
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      shreg_in  = shreg_ff;
      neg_in    = neg_ff;
      magnitude = dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);
      trial     = {rem_ff, shreg_ff[SAMPLE_BITS-1]};
      qbit      = (trial >= {1'b0, divisor});
      if (start) begin
         // top part of the magnitude is already below the divisor
         busy_in  = 1'b1;
         cnt_in   = CNT_BITS'(SAMPLE_BITS);
         rem_in   = WIN_BITS'(magnitude[SUM_BITS-1:SAMPLE_BITS]);
         shreg_in = magnitude[SAMPLE_BITS-1:0];
         neg_in   = dividend[SUM_BITS-1];
      end else if (busy_ff) begin
         rem_in   = qbit ? WIN_BITS'(trial - {1'b0, divisor}) : WIN_BITS'(trial);
         shreg_in = {shreg_ff[SAMPLE_BITS-2:0], qbit};
         cnt_in   = cnt_ff - CNT_BITS'(1);
         busy_in  = (cnt_ff != CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff   <= rem_in;
      shreg_ff <= shreg_in;
      neg_ff   <= neg_in;
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? $signed(-shreg_ff) : $signed(shreg_ff);

endmodule

### rtl/bsf_engine.sv
module bsf_engine #(
   parameter int SAMPLE_BITS = bsf_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_WINDOW  = bsf_pkg::MAX_WINDOW_DEF
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic [$clog2(MAX_WINDOW+1)-1:0]                   window,
   input  logic                                              frame_clear,
   input  logic                                              req_valid,
   input  logic signed [SAMPLE_BITS-1:0]                     req_sample,
   input  logic                                              req_last,
   output logic                                              req_ready,
   output logic                                              div_start,
   output logic signed [SAMPLE_BITS+$clog2(MAX_WINDOW)-1:0]  div_dividend,
   input  logic                                              div_busy,
   input  logic                                              slot_free,
   output bsf_pkg::emit_type                                 emit
);

   localparam int SUM_BITS  = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int WIN_BITS  = $clog2(MAX_WINDOW + 1);
   localparam int PTR_BITS  = $clog2(MAX_WINDOW);
   localparam int DIFF_BITS = WIN_BITS + 1;
   localparam logic [DIFF_BITS-1:0] RING_SIZE = DIFF_BITS'(MAX_WINDOW);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_UPDATE = 4'b0010,
      S_FSTART = 4'b0100,
      S_DIV    = 4'b1000
   } eng_state_type;

   eng_state_type state_ff, state_in;

   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [WIN_BITS-1:0]           fc_ff, fc_in;
   logic [PTR_BITS-1:0]           wp_ff, wp_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic                          last_ff, last_in;
   logic                          drop_ff, drop_in;
   logic                          flush_ff, flush_in;
   logic [WIN_BITS-1:0]           r_ff, r_in;
   logic [WIN_BITS-1:0]           k_ff, k_in;

   // delay line
   logic signed [SAMPLE_BITS-1:0] delay_mem_ff [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic                          mem_we;
   logic                          mem_re;
   logic [PTR_BITS-1:0]           mem_raddr;

   logic [WIN_BITS-1:0]  half, half_p1, after, fc_new, back_lag, k_next;
   logic [PTR_BITS-1:0]  wp_new, drop_addr, flush_addr;
   logic [DIFF_BITS-1:0] drop_diff, flush_diff;
   logic                 last_word;

   always_comb begin
      half    = window >> 1;
      half_p1 = half + WIN_BITS'(1);
      after   = window - WIN_BITS'(1) - half;
      fc_new  = (fc_ff == WIN_BITS'(MAX_WINDOW)) ? fc_ff : fc_ff + WIN_BITS'(1);
      wp_new  = (wp_ff == PTR_BITS'(MAX_WINDOW - 1)) ? '0 : wp_ff + PTR_BITS'(1);

      // ring slot of the sample leaving the window
      drop_diff = {1'b0, WIN_BITS'(wp_ff)} - {1'b0, window};
      drop_addr = drop_diff[DIFF_BITS-1] ? PTR_BITS'(drop_diff + RING_SIZE)
                                         : PTR_BITS'(drop_diff);

      // flush drops samples from the oldest side, counted back from the newest
      back_lag   = r_ff + after - WIN_BITS'(1) - k_ff;
      flush_diff = {1'b0, WIN_BITS'(wp_ff)} - DIFF_BITS'(1) - {1'b0, back_lag};
      flush_addr = flush_diff[DIFF_BITS-1] ? PTR_BITS'(flush_diff + RING_SIZE)
                                           : PTR_BITS'(flush_diff);

      k_next    = k_ff + WIN_BITS'(1);
      last_word = flush_ff && (k_next == r_ff);
   end

   always_comb begin
      state_in  = state_ff;
      sum_in    = sum_ff;
      fc_in     = fc_ff;
      wp_in     = wp_ff;
      x_in      = x_ff;
      last_in   = last_ff;
      drop_in   = drop_ff;
      flush_in  = flush_ff;
      r_in      = r_ff;
      k_in      = k_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_raddr = drop_addr;
      div_start = 1'b0;
      emit      = '{valid: 1'b0, last: 1'b0};
      req_ready = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               // write the new sample and fetch the one leaving together
               mem_we   = 1'b1;
               mem_re   = 1'b1;
               x_in     = req_sample;
               last_in  = req_last;
               drop_in  = (fc_ff >= window);
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            sum_in   = sum_ff + SUM_BITS'(x_ff)
                       - (drop_ff ? SUM_BITS'(rd_data_ff) : '0);
            fc_in    = fc_new;
            wp_in    = wp_new;
            flush_in = last_ff;
            r_in     = (fc_new < half_p1) ? fc_new : half_p1;
            k_in     = '0;
            if (last_ff || (fc_new >= half_p1)) begin
               state_in = S_FSTART;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FSTART: begin
            div_start = 1'b1;
            mem_re    = flush_ff;
            mem_raddr = flush_addr;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (!div_busy && slot_free) begin
               emit = '{valid: 1'b1, last: last_word};
               priority if (!flush_ff) begin
                  state_in = S_IDLE;
               end else if (last_word) begin
                  sum_in   = '0;
                  fc_in    = '0;
                  wp_in    = '0;
                  state_in = S_IDLE;
               end else begin
                  if (back_lag < fc_ff) begin
                     sum_in = sum_ff - SUM_BITS'(rd_data_ff);
                  end
                  k_in     = k_next;
                  state_in = S_FSTART;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a window length write starts a new frame
      if (frame_clear) begin
         sum_in = '0;
         fc_in  = '0;
         wp_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sum_ff   <= '0;
         fc_ff    <= '0;
         wp_ff    <= '0;
         flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         fc_ff    <= fc_in;
         wp_ff    <= wp_in;
         flush_ff <= flush_in;
      end
      x_ff    <= x_in;
      last_ff <= last_in;
      drop_ff <= drop_in;
      r_ff    <= r_in;
      k_ff    <= k_in;
   end

   // read-first: with a full-length window the slot read is the one written
   always_ff @(posedge clock) begin
      if (mem_we) begin
         delay_mem_ff[wp_ff] <= req_sample;
      end
      if (mem_re) begin
         rd_data_ff <= delay_mem_ff[mem_raddr];
      end
   end

   assign div_dividend = sum_ff;

endmodule

### rtl/boxcar_smoothing_filter_top.sv
// channel   direction  payload                        handshake
// req_if    in         sample, last_sample            valid / ready
// rsp_if    out        smoothed, last_output          valid / ready
// csr_*     in         window_length at byte addr 0   apb write, pready tied high
//
// a sample that gives no word passes through update and back to idle; one that
// gives a word also waits for the shift-subtract divider (one quotient bit a cycle).
// the end-of-frame flush runs the divider again for each further word.
// synchronous reset: window back to 5, frame cleared, delay line left as is.
// a finished word waits in the output register while the next sample is taken;
// the engine only stalls when a second word is ready before the first is taken.
module boxcar_smoothing_filter_top #(
   parameter int SAMPLE_BITS = bsf_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_WINDOW  = bsf_pkg::MAX_WINDOW_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   bsf_req_if.sink                            req_if,
   bsf_rsp_if.source                          rsp_if,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bsf_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [bsf_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [bsf_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int WIN_BITS = $clog2(MAX_WINDOW + 1);
   localparam int WIN_INIT = (bsf_pkg::WIN_RESET > MAX_WINDOW) ? MAX_WINDOW
                                                                : bsf_pkg::WIN_RESET;

   logic [WIN_BITS-1:0]             win_ff, win_in;
   logic [bsf_pkg::CFG_BITS-1:0]    cfg_val;
   logic                            cfg_wr;
   logic                            csr_hit;

   logic                            div_start;
   logic signed [SUM_BITS-1:0]      div_dividend;
   logic                            div_busy;
   logic signed [SAMPLE_BITS-1:0]   div_quotient;
   bsf_pkg::emit_type               emit;
   logic                            slot_free;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0]   rsp_smoothed_ff;
   logic                            rsp_last_ff;

   // window length register
   always_comb begin
      csr_hit = (csr_paddr[bsf_pkg::CSR_ADDR_BITS-1:2] == bsf_pkg::CSR_IDX_WINDOW);
      cfg_wr  = csr_psel && csr_penable && csr_pwrite && csr_hit;
      cfg_val = csr_pwdata[bsf_pkg::CFG_BITS-1:0];
      win_in  = win_ff;
      if (cfg_wr) begin
         priority if (cfg_val == '0) begin
            win_in = WIN_BITS'(1);
         end else if (cfg_val > bsf_pkg::CFG_BITS'(MAX_WINDOW)) begin
            win_in = WIN_BITS'(MAX_WINDOW);
         end else begin
            win_in = WIN_BITS'(cfg_val);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= WIN_BITS'(WIN_INIT);
      end else begin
         win_ff <= win_in;
      end
   end

   assign csr_prdata = csr_hit ? bsf_pkg::CSR_DATA_BITS'(win_ff) : '0;
   assign csr_pready = 1'b1;

   bsf_engine #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_WINDOW  (MAX_WINDOW)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .window       (win_ff),
      .frame_clear  (cfg_wr),
      .req_valid    (req_if.valid),
      .req_sample   (req_if.sample),
      .req_last     (req_if.last_sample),
      .req_ready    (req_if.ready),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_busy     (div_busy),
      .slot_free    (slot_free),
      .emit         (emit)
   );

   bsf_divider #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_WINDOW  (MAX_WINDOW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (win_ff),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   // output register
   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit.valid) begin
         rsp_smoothed_ff <= div_quotient;
         rsp_last_ff     <= emit.last;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.smoothed    = rsp_smoothed_ff;
   assign rsp_if.last_output = rsp_last_ff;

endmodule

### rtl/bsf_checker.sv
module bsf_checker #(
   parameter int SAMPLE_BITS = bsf_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_WINDOW  = bsf_pkg::MAX_WINDOW_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [SAMPLE_BITS-1:0]      rsp_smoothed,
   input logic                               rsp_last_output,
   input logic                               csr_psel,
   input logic                               csr_penable,
   input logic                               csr_pwrite,
   input logic [bsf_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input logic [bsf_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   input logic [bsf_pkg::CSR_DATA_BITS-1:0]  csr_prdata
);

   logic                         win_sel;
   logic [bsf_pkg::CFG_BITS-1:0] wdata;

   assign win_sel = (csr_paddr[bsf_pkg::CSR_ADDR_BITS-1:2] == bsf_pkg::CSR_IDX_WINDOW);
   assign wdata   = csr_pwdata[bsf_pkg::CFG_BITS-1:0];

   // a waiting word holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_smoothed) && $stable(rsp_last_output))
      else $error("output word changed while stalled");

   // the divider needs many cycles, so no word can follow a sample at once
   a_no_early_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !(rsp_valid && !$past(rsp_valid)))
      else $error("output word appeared one cycle after a sample");

   a_win_range: assert property (@(posedge clock) disable iff (reset)
      win_sel |-> (csr_prdata != '0 &&
                   csr_prdata <= bsf_pkg::CSR_DATA_BITS'(MAX_WINDOW)))
      else $error("window length outside its range");

   a_win_write: assert property (@(posedge clock) disable iff (reset)
      !reset && csr_psel && csr_penable && csr_pwrite && win_sel &&
      wdata != '0 && wdata <= bsf_pkg::CFG_BITS'(MAX_WINDOW) |=>
         (!win_sel || csr_prdata == bsf_pkg::CSR_DATA_BITS'($past(wdata))))
      else $error("window length write not taken");

endmodule

bind boxcar_smoothing_filter_top bsf_checker #(
   .SAMPLE_BITS (SAMPLE_BITS),
   .MAX_WINDOW  (MAX_WINDOW)
) u_bsf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_smoothed    (rsp_if.smoothed),
   .rsp_last_output (rsp_if.last_output),
   .csr_psel        (csr_psel),
   .csr_penable     (csr_penable),
   .csr_pwrite      (csr_pwrite),
   .csr_paddr       (csr_paddr),
   .csr_pwdata      (csr_pwdata),
   .csr_prdata      (csr_prdata)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import bsf_pkg::*;

   typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_type;

   typedef struct packed {
      sample_type smoothed;
      logic       last;
   } filtered_word_type;

   typedef enum int {
      FILL_UNIFORM,
      FILL_TOP,
      FILL_BOTTOM,
      FILL_SMALL,
      FILL_SWING
   } fill_style_type;

   localparam logic [CSR_IDX_BITS-1:0] CSR_IDX_UNMAPPED = 1'b1;
   localparam int          DRAIN_CYCLES = 2 * SAMPLE_BITS_DEF + 8;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int          PHASE_ITEMS  = 12;
   localparam int          FIXED_PHASES = 11;
   localparam int          PHASES       = FIXED_PHASES + 3;

   localparam logic [31:0] WINDOW_PLAN [FIXED_PHASES] = '{
      32'd1, 32'd64, 32'd2, 32'd127, 32'd3, 32'd0, 32'd33, 32'hFFFF_FF83, 32'd16, 32'd7,
      32'd64
   };

   // {last_sample, sample} for the opening frames, window at its reset length
   localparam logic [16:0] OPENING [25] = '{
      {1'b0, 16'h7FFF}, {1'b0, 16'h8000}, {1'b0, 16'h7FFF}, {1'b0, 16'h8000},
      {1'b0, 16'h0000}, {1'b0, 16'hFFFF}, {1'b1, 16'h0001},
      {1'b1, 16'h8000}, {1'b1, 16'h7FFF},
      {1'b0, 16'h0064}, {1'b1, 16'hFFF9},
      {1'b0, 16'h7FFF}, {1'b0, 16'h7FFF}, {1'b0, 16'h7FFF}, {1'b0, 16'h7FFF},
      {1'b0, 16'h7FFF}, {1'b1, 16'h7FFF},
      {1'b0, 16'h8000}, {1'b0, 16'h8000}, {1'b0, 16'h8000}, {1'b0, 16'h8000},
      {1'b0, 16'h8000}, {1'b1, 16'h8000},
      {1'b0, 16'h0001}, {1'b1, 16'hFFFE}
   };

   class smoothing_scoreboard;
      sample_type        taps [MAX_WINDOW_DEF];
      longint            win_sum;
      int                seen;
      int                wr_ptr;
      int                win_len;
      filtered_word_type expected_words [$];
      int                mismatches;
      int                words_checked;
      int                samples_taken;
      int                frames_closed;

      function new();
         win_len = WIN_RESET;
         clear_frame();
      endfunction

      function void clear_frame();
         win_sum = 0;
         seen    = 0;
         wr_ptr  = 0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void set_window(logic [31:0] value);
         int v;
         v = int'(value[CFG_BITS-1:0]);
         if (v == 0) v = 1;
         if (v > MAX_WINDOW_DEF) v = MAX_WINDOW_DEF;
         win_len = v;
         clear_frame();
      endfunction

      function void push_average(logic closes);
         filtered_word_type w;
         w.smoothed = sample_type'(win_sum / longint'(win_len));
         w.last     = closes;
         expected_words = {expected_words, w};
      endfunction

      function void note_sample(sample_type value, logic closes);
         int half, trail, count, lag;
         half  = win_len / 2;
         trail = win_len - 1 - half;
         samples_taken++;
         if (seen >= win_len)
            win_sum -= taps[(wr_ptr + MAX_WINDOW_DEF - win_len) % MAX_WINDOW_DEF];
         taps[wr_ptr] = value;
         wr_ptr = (wr_ptr + 1) % MAX_WINDOW_DEF;
         win_sum += value;
         if (seen < MAX_WINDOW_DEF) seen++;
         if (!closes) begin
            if (seen >= half + 1) push_average(1'b0);
            return;
         end
         // flush: the window gives up its oldest samples one by one
         count = (seen < half + 1) ? seen : half + 1;
         for (int k = 0; k < count; k++) begin
            lag = count - 1 - k + trail;
            push_average(k == count - 1);
            if (lag < seen)
               win_sum -= taps[(wr_ptr + MAX_WINDOW_DEF - 1 - lag) % MAX_WINDOW_DEF];
         end
         frames_closed++;
         clear_frame();
      endfunction

      task report(string msg);
         mismatches++;
         $display("mismatch: %s", msg);
      endtask

      task check_word(sample_type got_smoothed, logic got_last);
         filtered_word_type want;
         words_checked++;
         if (expected_words.size() == 0) begin
            report($sformatf("word %0d (smoothed %0d, last %0b) arrived unexpected",
                             words_checked, got_smoothed, got_last));
            return;
         end
         want = expected_words.pop_front();
         if (got_smoothed !== want.smoothed)
            report($sformatf("word %0d: smoothed %0d, expected %0d",
                             words_checked, got_smoothed, want.smoothed));
         if (got_last !== want.last)
            report($sformatf("word %0d: last_output %0b, expected %0b",
                             words_checked, got_last, want.last));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic        csr_pready;
   int unsigned cycles;
   int          req_gap_max;
   int          rsp_gap_max;
   smoothing_scoreboard board;

   bsf_req_if req_chan ();
   bsf_rsp_if rsp_chan ();

   boxcar_smoothing_filter_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_chan),
      .rsp_if      (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timed out with %0d words outstanding", board.pending());
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_sample(sample_type value, logic closes);
      int gap;
      gap = $urandom_range(req_gap_max, 0);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.sample      <= value;
      req_chan.last_sample <= closes;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      board.note_sample(value, closes);
   endtask

   // hold the sender until every expected word has been taken
   task automatic hold_for_words();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic settle();
      hold_for_words();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_BITS-1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (idx == CSR_IDX_WINDOW) board.set_window(value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic sample_type pick_sample(fill_style_type style);
      case (style)
         FILL_TOP:    return 16'h7FFF;
         FILL_BOTTOM: return 16'h8000;
         FILL_SMALL:  return sample_type'($urandom_range(15, 0)) - 16'sd8;
         FILL_SWING:  return ($urandom_range(1, 0) != 0) ? 16'h7FFF : 16'h8000;
         default:     return sample_type'($urandom);
      endcase
   endfunction

   function automatic fill_style_type pick_style();
      int roll;
      roll = $urandom_range(9, 0);
      if (roll < 6) return FILL_UNIFORM;
      if (roll == 6) return FILL_TOP;
      if (roll == 7) return FILL_BOTTOM;
      if (roll == 8) return FILL_SMALL;
      return FILL_SWING;
   endfunction

   function automatic int pick_frame_len(int w);
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 15) return $urandom_range(w / 2 + 1, 1);
      // long enough for the delay line to wrap and the count to saturate
      if (roll < 22) return $urandom_range(80, 65);
      return $urandom_range(w + w / 2 + 3, 1);
   endfunction

   task automatic send_frame(int len, logic closes);
      fill_style_type style;
      style = pick_style();
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(49, 0) == 0) hold_for_words();
         send_sample(pick_sample(style), closes && (i == len - 1));
      end
   endtask

   initial begin : word_sink
      int stall;
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = $urandom_range(rsp_gap_max, 0);
         @(negedge clock);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         board.check_word(rsp_chan.smoothed, rsp_chan.last_output);
      end
   end

   initial begin
      int          sent;
      int          len;
      logic [31:0] window;
      board                = new();
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.sample      = '0;
      req_chan.last_sample = 1'b0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      req_gap_max          = 10;
      rsp_gap_max          = 10;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 25; i++) begin
         if (i == 3) hold_for_words();
         send_sample(sample_type'(OPENING[i][15:0]), OPENING[i][16]);
      end

      for (int p = 0; p < PHASES; p++) begin
         settle();
         window = (p < FIXED_PHASES) ? WINDOW_PLAN[p] : 32'($urandom_range(64, 1));
         csr_write(CSR_IDX_WINDOW, window);
         if (p == 0) csr_write(CSR_IDX_UNMAPPED, 32'd9);
         req_gap_max = (p % 4 == 2) ? 0 : 10;
         rsp_gap_max = (p % 4 == 3 || p % 5 == 2) ? 0 : 10;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            len = pick_frame_len(board.win_len);
            send_frame(len, 1'b1);
            sent += len;
         end
         // leave a frame open so the next window write cuts it short
         if (p == 1 || $urandom_range(2, 0) == 0)
            send_frame($urandom_range(board.win_len + 4, 1), 1'b0);
      end

      settle();
      $display("covered %0d samples in %0d closed frames, %0d words checked",
               board.samples_taken, board.frames_closed, board.words_checked);
      $display("window lengths 1 to 64, frames cut by window writes, stalls on both sides");
      if (board.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
